>>> rtl/egl_pkg.sv
package egl_pkg;

    localparam int DEFAULT_OPERAND_W = 32;
    localparam int ANSWER_W          = 63;

    localparam logic [ANSWER_W-1:0] ANSWER_MAX = {ANSWER_W{1'b1}};

    typedef enum logic {
        CMD_GCD = 1'b0,
        CMD_LCM = 1'b1
    } t_command;

endpackage

>>> rtl/euclid_gcd_lcm_unit.sv
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   i_command, i_first_value, i_second_value
// result    out        o_valid, one cycle     o_answer
//
// One item at a time; busy stays high from the transfer until the result strobe.
// Each Euclid remainder step runs the bit-serial divider; an lcm of two nonzero operands
// adds a division of |a| by the gcd and a shift-add multiply of that quotient by |b|.
// Reset (synchronous, active low) returns the sequencer to idle and drops any item.
// The receiver cannot stall: o_valid is high for exactly one cycle per item.
module euclid_gcd_lcm_unit
    import egl_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_command,
    input  logic [OPERAND_WIDTH-1:0] i_first_value,
    input  logic [OPERAND_WIDTH-1:0] i_second_value,
    output logic                     o_valid,
    output logic [ANSWER_W-1:0]      o_answer
);

    localparam int W     = OPERAND_WIDTH;
    localparam int G_W   = (W > ANSWER_W) ? W : ANSWER_W;
    localparam int P_W   = (2 * W > ANSWER_W) ? 2 * W : ANSWER_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EUCLID,
        ST_REM_WAIT,
        ST_QUO_WAIT,
        ST_MUL_WAIT
    } t_state;

    t_state              r_state, n_state;
    t_command            r_cmd, n_cmd;
    logic [W-1:0]        r_ma, n_ma;
    logic [W-1:0]        r_mb, n_mb;
    logic [W-1:0]        r_x, n_x;
    logic [W-1:0]        r_y, n_y;
    logic                r_div_start, n_div_start;
    logic                r_mul_start, n_mul_start;
    logic                r_valid, n_valid;
    logic [ANSWER_W-1:0] r_answer, n_answer;

    logic [W-1:0]        mag_a, mag_b;
    logic                div_done, mul_done;
    logic [W-1:0]        quotient, remainder;
    logic [2*W-1:0]      product;
    logic [G_W-1:0]      gcd_ext;
    logic [P_W-1:0]      prod_ext;
    logic [ANSWER_W-1:0] gcd_answer, lcm_answer;

    // the most negative operand maps to 2^(W-1), which fits W unsigned bits
    assign mag_a = i_first_value[W-1]  ? (~i_first_value + 1'b1)  : i_first_value;
    assign mag_b = i_second_value[W-1] ? (~i_second_value + 1'b1) : i_second_value;

    assign gcd_ext    = G_W'(r_x);
    assign gcd_answer = (gcd_ext > G_W'(ANSWER_MAX)) ? ANSWER_MAX : gcd_ext[ANSWER_W-1:0];
    assign prod_ext   = P_W'(product);
    assign lcm_answer = (prod_ext > P_W'(ANSWER_MAX)) ? ANSWER_MAX : prod_ext[ANSWER_W-1:0];

    egl_divider #(
        .OPERAND_W (W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_x),
        .i_divisor   (r_y),
        .o_done      (div_done),
        .o_quotient  (quotient),
        .o_remainder (remainder)
    );

    egl_multiplier #(
        .OPERAND_W (W)
    ) u_multiplier (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (r_mul_start),
        .i_multiplier   (r_x),
        .i_multiplicand (r_mb),
        .o_done         (mul_done),
        .o_product      (product)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_x         = r_x;
        n_y         = r_y;
        n_div_start = 1'b0;
        n_mul_start = 1'b0;
        n_valid     = 1'b0;
        n_answer    = r_answer;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = t_command'(i_command);
                    n_ma    = mag_a;
                    n_mb    = mag_b;
                    n_x     = mag_a;
                    n_y     = mag_b;
                    n_state = ST_EUCLID;
                end
            end
            ST_EUCLID: begin
                if (r_y != '0) begin
                    n_div_start = 1'b1;
                    n_state     = ST_REM_WAIT;
                end else if (r_cmd == CMD_GCD) begin
                    n_answer = gcd_answer;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end else if (r_ma == '0 || r_mb == '0) begin
                    n_answer = '0;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    // lcm: divide |a| by the gcd, held in r_x
                    n_x         = r_ma;
                    n_y         = r_x;
                    n_div_start = 1'b1;
                    n_state     = ST_QUO_WAIT;
                end
            end
            ST_REM_WAIT: begin
                if (div_done) begin
                    n_x     = r_y;
                    n_y     = remainder;
                    n_state = ST_EUCLID;
                end
            end
            ST_QUO_WAIT: begin
                if (div_done) begin
                    n_x         = quotient;
                    n_mul_start = 1'b1;
                    n_state     = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    n_answer = lcm_answer;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_x      <= n_x;
        r_y      <= n_y;
        r_answer <= n_answer;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_mul_start <= n_mul_start;
            r_valid     <= n_valid;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_answer = r_answer;

endmodule

>>> rtl/egl_divider.sv
module egl_divider #(
    parameter int OPERAND_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [OPERAND_W-1:0] i_dividend,
    input  logic [OPERAND_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [OPERAND_W-1:0] o_quotient,
    output logic [OPERAND_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(OPERAND_W);

    logic [OPERAND_W-1:0] r_rem, n_rem;
    logic [OPERAND_W-1:0] r_quo, n_quo;
    logic [OPERAND_W-1:0] r_div, n_div;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_active, n_active;
    logic                 r_done, n_done;

    logic [OPERAND_W:0]   shifted;
    logic [OPERAND_W+1:0] diff;

    // one restoring step: bring down the next dividend bit, try a subtract
    assign shifted = {r_rem, r_quo[OPERAND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};

    always_comb begin
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_div    = r_div;
        n_count  = r_count;
        n_active = r_active;
        n_done   = 1'b0;
        if (i_start) begin
            n_rem    = '0;
            n_quo    = i_dividend;
            n_div    = i_divisor;
            n_count  = '0;
            n_active = 1'b1;
        end else if (r_active) begin
            if (diff[OPERAND_W+1]) begin
                n_rem = shifted[OPERAND_W-1:0];
                n_quo = {r_quo[OPERAND_W-2:0], 1'b0};
            end else begin
                n_rem = diff[OPERAND_W-1:0];
                n_quo = {r_quo[OPERAND_W-2:0], 1'b1};
            end
            n_count = r_count + 1'b1;
            if (r_count == CNT_W'(OPERAND_W - 1)) begin
                n_active = 1'b0;
                n_done   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_div   <= n_div;
        r_count <= n_count;
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_done   <= n_done;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> rtl/egl_multiplier.sv
module egl_multiplier #(
    parameter int OPERAND_W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [OPERAND_W-1:0]   i_multiplier,
    input  logic [OPERAND_W-1:0]   i_multiplicand,
    output logic                   o_done,
    output logic [2*OPERAND_W-1:0] o_product
);

    localparam int CNT_W = $clog2(OPERAND_W);

    logic [OPERAND_W-1:0] r_hi, n_hi;
    logic [OPERAND_W-1:0] r_lo, n_lo;
    logic [OPERAND_W-1:0] r_mcand, n_mcand;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_active, n_active;
    logic                 r_done, n_done;

    logic [OPERAND_W:0]   sum;

    // shift-add: add the multiplicand when the low bit is set, then shift right
    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    always_comb begin
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_mcand  = r_mcand;
        n_count  = r_count;
        n_active = r_active;
        n_done   = 1'b0;
        if (i_start) begin
            n_hi     = '0;
            n_lo     = i_multiplier;
            n_mcand  = i_multiplicand;
            n_count  = '0;
            n_active = 1'b1;
        end else if (r_active) begin
            n_hi    = sum[OPERAND_W:1];
            n_lo    = {sum[0], r_lo[OPERAND_W-1:1]};
            n_count = r_count + 1'b1;
            if (r_count == CNT_W'(OPERAND_W - 1)) begin
                n_active = 1'b0;
                n_done   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_mcand <= n_mcand;
        r_count <= n_count;
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_done   <= n_done;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

>>> bench/tb_euclid_gcd_lcm_unit.sv
module tb_euclid_gcd_lcm_unit;
    import egl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      OPERAND_W        = DEFAULT_OPERAND_W;
    localparam int      CLK_PERIOD_NS    = 10;
    localparam int      RANDOM_ITEMS     = 930;
    localparam int      MAX_IDLE         = 12;
    localparam int      DRAIN_CYCLES     = 4 * (OPERAND_W + 3);
    localparam longint  RUN_LIMIT_CYCLES = 10_000_000;

    // Worst-case Euclid chain that fits in 31 bits: consecutive Fibonacci numbers.
    localparam logic [OPERAND_W-1:0] FIB_46 = 32'd1836311903;
    localparam logic [OPERAND_W-1:0] FIB_45 = 32'd1134903170;

    typedef struct {
        t_command             cmd;
        logic [OPERAND_W-1:0] first;
        logic [OPERAND_W-1:0] second;
    } t_gcd_request;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  i_command      = 1'b0;
    logic [OPERAND_W-1:0]  i_first_value  = '0;
    logic [OPERAND_W-1:0]  i_second_value = '0;
    logic                  busy;
    logic                  o_valid;
    logic [ANSWER_W-1:0]   o_answer;

    t_gcd_request          request_q[$];
    logic [ANSWER_W-1:0]   answer_due_q[$];
    int                    mismatches = 0;
    int                    idle_left  = 0;
    bit                    gapless    = 1'b0;

    euclid_gcd_lcm_unit #(
        .OPERAND_WIDTH(OPERAND_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_first_value (i_first_value),
        .i_second_value(i_second_value),
        .o_valid       (o_valid),
        .o_answer      (o_answer)
    );

    always begin
        #(CLK_PERIOD_NS / 2) i_clk = 1'b1;
        #(CLK_PERIOD_NS / 2) i_clk = 1'b0;
    end

    function automatic logic [63:0] operand_magnitude(logic [OPERAND_W-1:0] v);
        logic [OPERAND_W-1:0] negated;
        negated = -v;
        return v[OPERAND_W-1] ? 64'(negated) : 64'(v);
    endfunction

    function automatic logic [ANSWER_W-1:0] predict_answer(t_command cmd,
                                                           logic [OPERAND_W-1:0] first,
                                                           logic [OPERAND_W-1:0] second);
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [63:0]  r;
        logic [127:0] full;
        mag_a = operand_magnitude(first);
        mag_b = operand_magnitude(second);
        x = mag_a;
        y = mag_b;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        if (cmd == CMD_GCD) begin
            full = 128'(x);
        end else if (mag_a == 0 || mag_b == 0) begin
            full = '0;
        end else begin
            full = 128'(mag_a / x) * 128'(mag_b);
        end
        return (full > 128'(ANSWER_MAX)) ? ANSWER_MAX : full[ANSWER_W-1:0];
    endfunction

    function automatic logic [OPERAND_W-1:0] random_sign(logic [OPERAND_W-1:0] v);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    function automatic logic [OPERAND_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0, 1, 2: return OPERAND_W'($urandom());
            3, 4:    return random_sign(OPERAND_W'($urandom()) >> $urandom_range(0, 31));
            5:       return random_sign(OPERAND_W'($urandom_range(0, 16)));
            6:       return random_sign(OPERAND_W'(1) << $urandom_range(0, OPERAND_W - 1));
            7: begin
                case ($urandom_range(0, 4))
                    0:       return {1'b1, {(OPERAND_W-1){1'b0}}};
                    1:       return {1'b0, {(OPERAND_W-1){1'b1}}};
                    2:       return '1;
                    3:       return '0;
                    default: return OPERAND_W'(1);
                endcase
            end
            default: return random_sign(OPERAND_W'($urandom_range(0, 4095)));
        endcase
    endfunction

    task automatic queue_request(t_command cmd, logic [OPERAND_W-1:0] first,
                                 logic [OPERAND_W-1:0] second);
        t_gcd_request req;
        req.cmd    = cmd;
        req.first  = first;
        req.second = second;
        request_q.insert(request_q.size(), req);
    endtask

    task automatic present_next();
        t_gcd_request req;
        req = request_q.pop_front();
        start          <= 1'b1;
        i_command      <= req.cmd;
        i_first_value  <= req.first;
        i_second_value <= req.second;
    endtask

    // Driver: idle cycles are counted only while the block is free, so gaps
    // land between items rather than being swallowed by the busy period.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            answer_due_q.insert(answer_due_q.size(),
                                predict_answer(t_command'(i_command),
                                               i_first_value, i_second_value));
            if ($urandom_range(0, 15) == 0)
                gapless = !gapless;
            idle_left = gapless ? 0 : $urandom_range(0, MAX_IDLE);
            if (idle_left == 0 && request_q.size() != 0)
                present_next();
            else
                start <= 1'b0;
        end else if (!start && request_q.size() != 0) begin
            if (idle_left != 0) begin
                if (!busy)
                    idle_left = idle_left - 1;
            end else begin
                present_next();
            end
        end
    end

    always @(posedge i_clk) begin : answer_monitor
        logic [ANSWER_W-1:0] expected_answer;
        if (i_rst_n && o_valid) begin
            if (answer_due_q.size() == 0) begin
                $error("answer: no transfer pending, got %0d", o_answer);
                mismatches++;
            end else begin
                expected_answer = answer_due_q.pop_front();
                if (o_answer !== expected_answer) begin
                    $error("answer: expected %0d, actual %0d", expected_answer, o_answer);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        int unsigned          factor;
        logic [OPERAND_W-1:0] first;
        logic [OPERAND_W-1:0] second;

        // Zero operands, most negative value, widest lcm, longest Euclid chain.
        queue_request(CMD_GCD, 32'd0, 32'd0);
        queue_request(CMD_LCM, 32'd0, 32'd0);
        queue_request(CMD_GCD, 32'd0, -32'sd7);
        queue_request(CMD_GCD, 32'd12, 32'd0);
        queue_request(CMD_LCM, 32'd0, 32'd5);
        queue_request(CMD_LCM, -32'sd9, 32'd0);
        queue_request(CMD_GCD, 32'h8000_0000, 32'd0);
        queue_request(CMD_GCD, 32'h8000_0000, 32'h8000_0000);
        queue_request(CMD_LCM, 32'h8000_0000, 32'h8000_0000);
        queue_request(CMD_LCM, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(CMD_LCM, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
        queue_request(CMD_LCM, 32'h8000_0000, 32'd1);
        queue_request(CMD_LCM, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_request(CMD_GCD, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(CMD_GCD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(CMD_GCD, FIB_46, FIB_45);
        queue_request(CMD_LCM, FIB_46, -FIB_45);
        queue_request(CMD_GCD, -32'sd12, 32'd18);
        queue_request(CMD_LCM, -32'sd4, 32'd6);
        queue_request(CMD_LCM, -32'sd1, -32'sd1);
        queue_request(CMD_GCD, 32'd1, 32'd1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                // Build a shared factor into both operands, so the gcd is a multiple of it.
                factor = $urandom_range(1, 1 << $urandom_range(0, 15));
                first  = random_sign(OPERAND_W'(factor * $urandom_range(0, 65535)));
                second = random_sign(OPERAND_W'(factor * $urandom_range(0, 65535)));
            end else begin
                first  = random_operand();
                second = random_operand();
            end
            queue_request(t_command'($urandom_range(0, 1)), first, second);
        end

        wait (i_rst_n);
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || start || answer_due_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD_NS);
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/egl_pkg.sv
rtl/egl_divider.sv
rtl/egl_multiplier.sv
rtl/euclid_gcd_lcm_unit.sv
bench/tb_euclid_gcd_lcm_unit.sv
